// File: design/sma_pkg.sv
// shared types, constants and codes of the stack machine alu
package sma_pkg;

    localparam int DATA_W      = 32;
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 3;
    localparam int DEPTH_W     = 5;

    localparam int STACK_DEPTH = 16;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int STACK_CW    = $clog2(STACK_DEPTH + 1);

    localparam int OPQ_DEPTH   = 2;
    localparam int OPQ_AW      = $clog2(OPQ_DEPTH);
    localparam int OPQ_CW      = $clog2(OPQ_DEPTH + 1);

    localparam int DIV_STEPS   = DATA_W;
    localparam int DIV_CW      = $clog2(DIV_STEPS + 1);

    localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADD  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SUB  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MUL  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DIV  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_MOVE = 3'd6;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FEW     = 3'd1,
        ST_FULL    = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_DIVZERO = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        K_PUSH,
        K_POP,
        K_ADD,
        K_SUB,
        K_MUL,
        K_DIV,
        K_MOVE,
        K_NOP
    } op_kind_t;

    // decoded instruction as it travels from the front to the back
    typedef struct packed {
        op_kind_t            kind;
        logic [1:0]          min_count;
        logic [DATA_W-1:0]   value;
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_DIV
    } back_state_t;

endpackage

// File: design/sma_front.sv
// front end: decodes a command and sorts it by the stack entries it consumes
module sma_front (
    input  logic [sma_pkg::CMD_W-1:0]  cmd,
    input  logic [sma_pkg::DATA_W-1:0] operand_value,
    output sma_pkg::op_t               op
);
    import sma_pkg::*;

    always_comb
    begin
        op.value     = operand_value;
        op.kind      = K_NOP;
        op.min_count = 2'd0;
        unique case (cmd)
            CMD_PUSH:
            begin
                op.kind = K_PUSH;
            end
            CMD_POP:
            begin
                op.kind      = K_POP;
                op.min_count = 2'd1;
            end
            CMD_ADD:
            begin
                op.kind      = K_ADD;
                op.min_count = 2'd2;
            end
            CMD_SUB:
            begin
                op.kind      = K_SUB;
                op.min_count = 2'd2;
            end
            CMD_MUL:
            begin
                op.kind      = K_MUL;
                op.min_count = 2'd2;
            end
            CMD_DIV:
            begin
                op.kind      = K_DIV;
                op.min_count = 2'd2;
            end
            CMD_MOVE:
            begin
                op.kind = K_MOVE;
            end
            default:
            begin
                op.kind = K_NOP;
            end
        endcase
    end

endmodule

// File: design/sma_opq.sv
// short instruction queue between the front end and the execute back end
module sma_opq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  sma_pkg::op_t  wr_op,
    input  logic          rd_en,
    output sma_pkg::op_t  rd_op,
    output logic          full,
    output logic          empty
);
    import sma_pkg::*;

    op_t                 q_mem [OPQ_DEPTH];
    logic [OPQ_AW-1:0]   wr_ptr_reg;
    logic [OPQ_AW-1:0]   wr_ptr_next;
    logic [OPQ_AW-1:0]   rd_ptr_reg;
    logic [OPQ_AW-1:0]   rd_ptr_next;
    logic [OPQ_CW-1:0]   cnt_reg;
    logic [OPQ_CW-1:0]   cnt_next;

    assign full  = (cnt_reg == OPQ_CW'(OPQ_DEPTH));
    assign empty = (cnt_reg == '0);
    assign rd_op = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == OPQ_AW'(OPQ_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + OPQ_AW'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == OPQ_AW'(OPQ_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + OPQ_AW'(1);
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + OPQ_CW'(1);
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - OPQ_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_mem[wr_ptr_reg] <= wr_op;
        end
    end

endmodule

// File: design/sma_div.sv
// iterative signed divider, one quotient bit per cycle, truncating toward zero
module sma_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [sma_pkg::DATA_W-1:0] dividend,
    input  logic [sma_pkg::DATA_W-1:0] divisor,
    output logic                       done,
    output logic [sma_pkg::DATA_W-1:0] quotient
);
    import sma_pkg::*;

    logic                busy_reg;
    logic                busy_next;
    logic                done_reg;
    logic                done_next;
    logic [DIV_CW-1:0]   cnt_reg;
    logic [DIV_CW-1:0]   cnt_next;
    logic                neg_reg;
    logic                neg_next;
    logic [DATA_W-1:0]   quo_reg;
    logic [DATA_W-1:0]   quo_next;
    logic [DATA_W-1:0]   rem_reg;
    logic [DATA_W-1:0]   rem_next;
    logic [DATA_W-1:0]   dvs_reg;
    logic [DATA_W-1:0]   dvs_next;
    logic [DATA_W:0]     rem_shift;
    logic [DATA_W+1:0]   diff;
    logic                fits;

    assign rem_shift = {rem_reg, quo_reg[DATA_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, dvs_reg};
    assign fits      = !diff[DATA_W+1];
    assign done      = done_reg;
    assign quotient  = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            // magnitudes in, sign fixed up on the way out
            busy_next = 1'b1;
            cnt_next  = DIV_CW'(DIV_STEPS);
            neg_next  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
            quo_next  = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
            dvs_next  = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DATA_W-1:0] : rem_shift[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], fits};
            cnt_next = cnt_reg - DIV_CW'(1);
            if (cnt_reg == DIV_CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("divider done without a finished run");
`endif

endmodule

// File: design/sma_back.sv
// execute back end: operand stack ram, accumulator, alu and result register
module sma_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sma_pkg::op_t                  q_op,
    input  logic                          q_empty,
    output logic                          q_pop,
    input  logic                          pop,
    output logic                          out_valid,
    output logic [sma_pkg::STATUS_W-1:0]  status,
    output logic [sma_pkg::DATA_W-1:0]    result_value,
    output logic [sma_pkg::DATA_W-1:0]    register_value,
    output logic [sma_pkg::DEPTH_W-1:0]   stack_depth
);
    import sma_pkg::*;

    back_state_t           state_reg;
    back_state_t           state_next;
    op_t                   op_reg;
    logic [STACK_CW-1:0]   count_reg;
    logic [STACK_CW-1:0]   count_next;
    logic [DATA_W-1:0]     acc_reg;
    logic [DATA_W-1:0]     acc_next;

    logic [DATA_W-1:0]     stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0]     rd_top_reg;
    logic [DATA_W-1:0]     rd_below_reg;
    logic                  rd_en;
    logic                  mem_we;
    logic [STACK_AW-1:0]   mem_waddr;
    logic [DATA_W-1:0]     mem_wdata;

    logic [STACK_CW-1:0]   top_cnt;
    logic [STACK_CW-1:0]   below_cnt;
    logic [STACK_AW-1:0]   top_idx;
    logic [STACK_AW-1:0]   below_idx;

    logic [DATA_W-1:0]     product;
    logic [DATA_W-1:0]     alu_res;
    logic                  div_start;
    logic                  div_done;
    logic [DATA_W-1:0]     div_quo;

    logic                  out_valid_reg;
    status_t               out_status_reg;
    logic [DATA_W-1:0]     out_result_reg;
    logic [DATA_W-1:0]     out_acc_reg;
    logic [DEPTH_W-1:0]    out_depth_reg;
    logic [DEPTH_W+STACK_CW-1:0] depth_ext;

    logic                  can_emit;
    logic                  emit;
    status_t               emit_status;
    logic [DATA_W-1:0]     emit_result;

    assign top_cnt   = count_reg - STACK_CW'(1);
    assign below_cnt = count_reg - STACK_CW'(2);
    assign top_idx   = top_cnt[STACK_AW-1:0];
    assign below_idx = below_cnt[STACK_AW-1:0];
    assign depth_ext = {DEPTH_W'(0), count_next};

    // the slot is free now or frees this cycle; once claimed it stays ours
    assign can_emit = !out_valid_reg || pop;

    assign product = rd_below_reg * rd_top_reg;

    always_comb
    begin
        unique case (op_reg.kind)
            K_ADD:   alu_res = rd_below_reg + rd_top_reg;
            K_SUB:   alu_res = rd_below_reg - rd_top_reg;
            default: alu_res = product;
        endcase
    end

    sma_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rd_below_reg),
        .divisor  (rd_top_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        acc_next    = acc_reg;
        q_pop       = 1'b0;
        rd_en       = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = below_idx;
        mem_wdata   = alu_res;
        div_start   = 1'b0;
        emit        = 1'b0;
        emit_status = ST_OK;
        emit_result = '0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty && can_emit)
                begin
                    q_pop = 1'b1;
                    priority if (q_op.kind == K_PUSH)
                    begin
                        emit = 1'b1;
                        if (count_reg == STACK_CW'(STACK_DEPTH))
                        begin
                            emit_status = ST_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[STACK_AW-1:0];
                            mem_wdata  = q_op.value;
                            count_next = count_reg + STACK_CW'(1);
                        end
                    end
                    else if (count_reg < STACK_CW'(q_op.min_count))
                    begin
                        emit        = 1'b1;
                        emit_status = (q_op.kind == K_POP) ? ST_EMPTY : ST_FEW;
                    end
                    else if (q_op.min_count != 2'd0)
                    begin
                        rd_en      = 1'b1;
                        state_next = BK_READ;
                    end
                    else
                    begin
                        if (q_op.kind == K_MOVE)
                        begin
                            acc_next = q_op.value;
                        end
                        emit = 1'b1;
                    end
                end
            end
            BK_READ:
            begin
                state_next = BK_IDLE;
                unique case (op_reg.kind)
                    K_POP:
                    begin
                        emit        = 1'b1;
                        emit_result = rd_top_reg;
                        count_next  = top_cnt;
                    end
                    K_ADD, K_SUB, K_MUL:
                    begin
                        emit        = 1'b1;
                        emit_result = alu_res;
                        mem_we      = 1'b1;
                        count_next  = top_cnt;
                    end
                    K_DIV:
                    begin
                        if (rd_top_reg == '0)
                        begin
                            emit        = 1'b1;
                            emit_status = ST_DIVZERO;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = BK_DIV;
                        end
                    end
                    default:
                    begin
                        state_next = BK_IDLE;
                    end
                endcase
            end
            BK_DIV:
            begin
                if (div_done)
                begin
                    emit        = 1'b1;
                    emit_result = div_quo;
                    mem_we      = 1'b1;
                    mem_wdata   = div_quo;
                    count_next  = top_cnt;
                    state_next  = BK_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_reg <= q_op;
        end
        if (rd_en)
        begin
            rd_top_reg   <= stack_mem[top_idx];
            rd_below_reg <= stack_mem[below_idx];
        end
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (emit)
        begin
            out_status_reg <= emit_status;
            out_result_reg <= emit_result;
            out_acc_reg    <= acc_next;
            out_depth_reg  <= depth_ext[DEPTH_W-1:0];
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign result_value   = out_result_reg;
    assign register_value = out_acc_reg;
    assign stack_depth    = out_depth_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= STACK_CW'(STACK_DEPTH))
        else $error("stack count beyond capacity");

    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || pop))
        else $error("result written over a waiting transaction");

    a_read_after_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_READ) |-> $past(rd_en))
        else $error("operands used without a fresh read");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == BK_DIV))
        else $error("quotient arrived outside divide wait");
`endif

endmodule

// File: design/stack_machine_alu.sv
// Stack machine execute unit with a 16-entry operand stack of 32-bit values and
// one accumulator register; every accepted instruction returns exactly one result
// transaction. Commands land in a two-entry instruction queue, so new transactions
// are taken while the execute side is busy or a result waits to be popped. Once an
// instruction reaches the execute side, push, move, the unused code and any error
// caught on the stack count are finished at dispatch; pop, add, subtract and
// multiply also pass a read state because the stack RAM has registered read ports;
// divide then waits on the radix-2 iterative divider (32 steps plus start and finish).
// Entries are read only after they were written, so the stack RAM needs no clearing.
module stack_machine_alu (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [2:0]          cmd,
    input  logic signed [31:0]  operand_value,
    output logic                empty,
    input  logic                pop,
    output logic [2:0]          status,
    output logic signed [31:0]  result_value,
    output logic signed [31:0]  register_value,
    output logic [4:0]          stack_depth
);
    import sma_pkg::*;

    op_t   dec_op;
    op_t   q_op;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;
    logic  out_valid;

    sma_front u_front (
        .cmd           (cmd),
        .operand_value (operand_value),
        .op            (dec_op)
    );

    sma_opq u_opq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (push && !q_full),
        .wr_op (dec_op),
        .rd_en (q_pop),
        .rd_op (q_op),
        .full  (q_full),
        .empty (q_empty)
    );

    sma_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_op           (q_op),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .pop            (pop && out_valid),
        .out_valid      (out_valid),
        .status         (status),
        .result_value   (result_value),
        .register_value (register_value),
        .stack_depth    (stack_depth)
    );

    assign full  = q_full;
    assign empty = !out_valid;

endmodule

// File: bench/tb_top.sv
// testbench for the stack machine alu: directed and random instruction streams
`timescale 1ns / 100ps

module tb_top;
    import sma_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
    localparam int               STALL_LIMIT = 4000;
    localparam int               DRAIN_CYCLES = 60;
    localparam int               PHASE_ITEMS = 370;
    localparam int               MAX_REPORTS = 10;

    typedef struct {
        status_t             status;
        logic [DATA_W-1:0]   result;
        logic [DATA_W-1:0]   acc;
        logic [DEPTH_W-1:0]  depth;
    } outcome_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    logic [CMD_W-1:0]    cmd = CMD_PUSH;
    logic signed [31:0]  operand_value = '0;
    logic                empty;
    logic                pop = 1'b0;
    logic [STATUS_W-1:0] status;
    logic signed [31:0]  result_value;
    logic signed [31:0]  register_value;
    logic [DEPTH_W-1:0]  stack_depth;

    // shadow of the execute unit
    logic [DATA_W-1:0]   stk_mem [STACK_DEPTH];
    int                  stk_cnt = 0;
    logic [DATA_W-1:0]   acc_reg = '0;

    outcome_t            outcome_q[$];
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int                  fault_cnt = 0;
    int                  instr_cnt = 0;
    int                  checked_cnt = 0;
    int                  status_hits[5] = '{default: 0};
    int                  quiet_cycles = 0;

    stack_machine_alu u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .cmd            (cmd),
        .operand_value  (operand_value),
        .empty          (empty),
        .pop            (pop),
        .status         (status),
        .result_value   (result_value),
        .register_value (register_value),
        .stack_depth    (stack_depth)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic outcome_t stack_exec(input logic [CMD_W-1:0] c,
                                            input logic [DATA_W-1:0] v);
        outcome_t          o;
        logic [DATA_W-1:0] top;
        logic [DATA_W-1:0] below;
        logic [DATA_W-1:0] res;
        status_t           st;
        st  = ST_OK;
        res = '0;
        case (c)
            CMD_PUSH:
            begin
                if (stk_cnt >= STACK_DEPTH)
                    st = ST_FULL;
                else
                begin
                    stk_mem[stk_cnt] = v;
                    stk_cnt++;
                end
            end
            CMD_POP:
            begin
                if (stk_cnt == 0)
                    st = ST_EMPTY;
                else
                begin
                    stk_cnt--;
                    res = stk_mem[stk_cnt];
                end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV:
            begin
                if (stk_cnt < 2)
                    st = ST_FEW;
                else
                begin
                    top   = stk_mem[stk_cnt-1];
                    below = stk_mem[stk_cnt-2];
                    if (c == CMD_ADD)
                        res = below + top;
                    else if (c == CMD_SUB)
                        res = below - top;
                    else if (c == CMD_MUL)
                        res = below * top;
                    else if (top == '0)
                        st = ST_DIVZERO;
                    else if (below == 32'h8000_0000 && top == 32'hffff_ffff)
                        res = 32'h8000_0000;
                    else
                        res = $signed(below) / $signed(top);
                    if (st == ST_OK)
                    begin
                        stk_cnt--;
                        stk_mem[stk_cnt-1] = res;
                    end
                end
            end
            CMD_MOVE:
                acc_reg = v;
            default:
                ;
        endcase
        o.status = st;
        o.result = res;
        o.acc    = acc_reg;
        o.depth  = stk_cnt[DEPTH_W-1:0];
        return o;
    endfunction

    task automatic report_fault(input string msg);
        fault_cnt++;
        if (fault_cnt <= MAX_REPORTS)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    // sends one instruction, with a random idle gap in front
    task automatic send_instr(input logic [CMD_W-1:0] c, input logic [DATA_W-1:0] v);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push          <= 1'b1;
        cmd           <= c;
        operand_value <= v;
        @(posedge clk);
        while (full)
            @(posedge clk);
        outcome_q.push_back(stack_exec(c, v));
        instr_cnt++;
    endtask

    task automatic wait_drained();
        while (outcome_q.size() != 0)
            @(posedge clk);
    endtask

    // result side: check every transaction, then pick the next stall
    always @(posedge clk)
    begin
        outcome_t o;
        if (rst_n && pop && !empty)
        begin
            if (outcome_q.size() == 0)
                report_fault($sformatf("result with nothing pending: st=%0d res=%h",
                                       status, result_value));
            else
            begin
                o = outcome_q.pop_front();
                checked_cnt++;
                if (o.status <= ST_DIVZERO)
                    status_hits[o.status]++;
                if (status !== o.status || result_value !== o.result ||
                    register_value !== o.acc || stack_depth !== o.depth)
                    report_fault($sformatf(
                        "#%0d st %0d/%0d res %h/%h reg %h/%h depth %0d/%0d (exp/act)",
                        checked_cnt, o.status, status, o.result, result_value,
                        o.acc, register_value, o.depth, stack_depth));
            end
        end
        pop <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("[stack_machine_alu] ERROR");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return '0;
            1: return 32'd1;
            2: return 32'hffff_ffff;
            3: return 32'h8000_0000;
            4: return 32'h7fff_ffff;
            5: return $urandom_range(20) - 10;
            default: return $urandom;
        endcase
    endfunction

    // biased by the shadow depth so the stack wanders over its whole range
    function automatic logic [CMD_W-1:0] pick_cmd();
        int push_w;
        int r;
        push_w = (stk_cnt < 4) ? 50 : (stk_cnt > 13) ? 15 : 30;
        if ($urandom_range(99) < push_w)
            return CMD_PUSH;
        r = $urandom_range(99);
        if (r < 20)      return CMD_POP;
        else if (r < 40) return CMD_ADD;
        else if (r < 58) return CMD_SUB;
        else if (r < 76) return CMD_MUL;
        else if (r < 88) return CMD_DIV;
        else if (r < 99) return CMD_MOVE;
        else             return CMD_UNUSED;
    endfunction

    task automatic test_directed_ops();
        send_instr(CMD_POP, 32'h1234_5678);        // pop from empty stack
        send_instr(CMD_ADD, '0);                   // too few operands
        send_instr(CMD_PUSH, 32'h7fff_ffff);
        send_instr(CMD_DIV, '0);                   // one operand only
        send_instr(CMD_PUSH, 32'd1);
        send_instr(CMD_ADD, 32'hdead_beef);        // wraps to most negative
        send_instr(CMD_PUSH, 32'hffff_ffff);
        send_instr(CMD_DIV, '0);                   // most negative by minus one
        send_instr(CMD_PUSH, '0);
        send_instr(CMD_DIV, '0);                   // divide by zero keeps both
        send_instr(CMD_POP, '0);
        send_instr(CMD_PUSH, 32'd3);
        send_instr(CMD_MUL, '0);
        send_instr(CMD_PUSH, 32'd7);
        send_instr(CMD_SUB, '0);
        send_instr(CMD_PUSH, 32'hffff_fff9);
        send_instr(CMD_DIV, '0);                   // negative quotient truncation
        send_instr(CMD_PUSH, 32'hffff_fffe);
        send_instr(CMD_DIV, '0);
        send_instr(CMD_MOVE, 32'h8000_0000);
        send_instr(CMD_MOVE, 32'h7fff_ffff);
        send_instr(CMD_UNUSED, 32'h5555_aaaa);
        send_instr(CMD_POP, '0);
        send_instr(CMD_POP, '0);
    endtask

    task automatic test_stack_limits();
        for (int i = 0; i <= STACK_DEPTH; i++)
            send_instr(CMD_PUSH, $urandom);
        for (int i = 0; i <= STACK_DEPTH; i++)
            send_instr(CMD_POP, '0);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        int n;
        bit paused;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        n = 0;
        paused = 1'b0;
        while (n < PHASE_ITEMS)
        begin
            if (!paused && n >= PHASE_ITEMS / 2)
            begin
                // hold the sender until every pending transaction is back
                push <= 1'b0;
                wait_drained();
                paused = 1'b1;
            end
            if ($urandom_range(99) < 2)
            begin
                // burst into the full or empty boundary
                for (int i = 0; i < 18; i++)
                    send_instr(($urandom_range(1) != 0) ? CMD_PUSH : CMD_POP,
                               pick_value());
                n += 18;
            end
            else
            begin
                send_instr(pick_cmd(), pick_value());
                n++;
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_ops();
        test_stack_limits();
        test_random_traffic(0, 0);
        test_random_traffic(81, 0);
        test_random_traffic(0, 81);
        test_random_traffic(34, 34);

        push <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (outcome_q.size() != 0)
            report_fault($sformatf("%0d results never arrived", outcome_q.size()));

        $display("run: %0d instructions sent, %0d results checked, %0d faults",
                 instr_cnt, checked_cnt, fault_cnt);
        $display("status mix: ok %0d, few %0d, full %0d, empty %0d, div0 %0d",
                 status_hits[ST_OK], status_hits[ST_FEW], status_hits[ST_FULL],
                 status_hits[ST_EMPTY], status_hits[ST_DIVZERO]);
        if (fault_cnt == 0)
            $display("[stack_machine_alu] OK");
        else
            $display("[stack_machine_alu] ERROR");
        $finish;
    end

endmodule

// File: stack_machine_alu.f
design/sma_pkg.sv
design/sma_front.sv
design/sma_opq.sv
design/sma_div.sv
design/sma_back.sv
design/stack_machine_alu.sv
bench/tb_top.sv
